>>> src/lpms_pkg.sv
package lpms_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxBoardsDefault  = 256;
  localparam int unsigned LengthBitsDefault = 16;

  // Fixed field widths of the configuration register and the result.
  localparam int unsigned PainterW     = 16;
  localparam int unsigned TimeW        = 24;
  localparam int unsigned PainterReset = 1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_MID,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear_set;
    logic search_init;
    logic mid_calc;
    logic scan_step;
    logic decide;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic painters_zero;
    logic low_gt_high;
    logic scan_done;
    logic fits;
    logic mid_zero;
    logic out_free;
  } status_t;

endpackage

>>> src/lpms_board_if.sv
interface lpms_board_if #(
  parameter int unsigned LENGTH_BITS = lpms_pkg::LengthBitsDefault
);
  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS-1:0] board_length;
  logic                   last_board;

  modport source (output valid, output board_length, output last_board, input ready);
  modport sink   (input valid, input board_length, input last_board, output ready);
endinterface

>>> src/lpms_result_if.sv
interface lpms_result_if;
  logic                        valid;
  logic                        ready;
  logic [lpms_pkg::TimeW-1:0]  min_time;
  logic                        feasible;
  logic                        overflow;

  modport source (output valid, output min_time, output feasible, output overflow,
                  input ready);
  modport sink   (input valid, input min_time, input feasible, input overflow,
                  output ready);
endinterface

>>> src/lpms_ctrl.sv
module lpms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  lpms_pkg::status_t status_i,
  output lpms_pkg::cmd_t    cmd_o
);

  lpms_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpms_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lpms_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = lpms_pkg::ST_INIT;
          end
        end
      end
      lpms_pkg::ST_INIT: begin
        cmd_o.search_init = 1'b1;
        if (status_i.painters_zero) begin
          state_d = lpms_pkg::ST_EMIT;
        end else begin
          state_d = lpms_pkg::ST_MID;
        end
      end
      lpms_pkg::ST_MID: begin
        if (status_i.low_gt_high) begin
          state_d = lpms_pkg::ST_EMIT;
        end else begin
          cmd_o.mid_calc = 1'b1;
          state_d        = lpms_pkg::ST_SCAN;
        end
      end
      lpms_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = lpms_pkg::ST_DECIDE;
        end
      end
      lpms_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        // A fitting limit of zero cannot be lowered any further.
        if (status_i.fits && status_i.mid_zero) begin
          state_d = lpms_pkg::ST_EMIT;
        end else begin
          state_d = lpms_pkg::ST_MID;
        end
      end
      lpms_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.clear_set = 1'b1;
          state_d         = lpms_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = lpms_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

>>> src/lpms_datapath.sv
module lpms_datapath #(
  parameter int unsigned MAX_BOARDS  = lpms_pkg::MaxBoardsDefault,
  parameter int unsigned LENGTH_BITS = lpms_pkg::LengthBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpms_pkg::PainterW-1:0] cfg_wdata_i,
  input  logic [LENGTH_BITS-1:0]        board_length_i,
  input  lpms_pkg::cmd_t                cmd_i,
  output lpms_pkg::status_t             status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [lpms_pkg::TimeW-1:0]    min_time_o,
  output logic                          feasible_o,
  output logic                          overflow_o
);

  localparam int unsigned CntW  = $clog2(MAX_BOARDS + 1);
  localparam int unsigned AddrW = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
  localparam int unsigned SumW  = LENGTH_BITS + CntW;
  localparam int unsigned GcW   = (CntW > lpms_pkg::PainterW) ? CntW : lpms_pkg::PainterW;
  localparam int unsigned CmpW  = (SumW > lpms_pkg::TimeW) ? SumW : lpms_pkg::TimeW;
  localparam logic [lpms_pkg::TimeW-1:0] TimeMax = {lpms_pkg::TimeW{1'b1}};

  logic [lpms_pkg::PainterW-1:0] painter_q;
  logic [CntW-1:0]               count_q;
  logic [LENGTH_BITS-1:0]        longest_q;
  logic [SumW-1:0]               total_q;
  logic                          dropped_q;
  logic [SumW-1:0]               low_q, high_q, mid_q, best_q;
  logic                          ok_q;
  logic [SumW-1:0]               gsum_q;
  logic [CntW-1:0]               gcnt_q;
  logic                          fail_q;
  logic [CntW-1:0]               idx_q;
  logic                          rd_vld_q;
  logic [LENGTH_BITS-1:0]        rd_data_q;
  logic                          out_valid_q;
  logic [lpms_pkg::TimeW-1:0]    min_time_q;
  logic                          feasible_q;
  logic                          overflow_q;

  logic [LENGTH_BITS-1:0] store_mem [MAX_BOARDS];

  logic            store_full;
  logic            read_issue;
  logic [SumW-1:0] len_ext;
  logic [SumW-1:0] sum_next;
  logic            fits;
  logic [CmpW-1:0] best_wide;
  logic [lpms_pkg::TimeW-1:0] time_sat;

  assign store_full = (count_q == CntW'(MAX_BOARDS));
  assign read_issue = cmd_i.scan_step && (idx_q != count_q);
  assign len_ext    = SumW'(rd_data_q);
  assign sum_next   = gsum_q + len_ext;
  assign fits       = !fail_q && (GcW'(gcnt_q) <= GcW'(painter_q));
  assign best_wide  = CmpW'(best_q);
  assign time_sat   = (best_wide > CmpW'(TimeMax)) ? TimeMax
                                                   : best_wide[lpms_pkg::TimeW-1:0];

  // Painter count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      painter_q <= lpms_pkg::PainterW'(lpms_pkg::PainterReset);
    end else if (cfg_we_i) begin
      painter_q <= cfg_wdata_i;
    end
  end

  // Set bookkeeping: count, longest board, total length and drop flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      longest_q <= '0;
      total_q   <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.clear_set) begin
      count_q   <= '0;
      longest_q <= '0;
      total_q   <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (store_full) begin
        dropped_q <= 1'b1;
      end else begin
        count_q <= count_q + 1'b1;
        total_q <= total_q + SumW'(board_length_i);
        if (board_length_i > longest_q) begin
          longest_q <= board_length_i;
        end
      end
    end
  end

  // Board store write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !store_full) begin
      store_mem[count_q[AddrW-1:0]] <= board_length_i;
    end
  end

  // Board store read port, registered.
  always_ff @(posedge clk_i) begin
    if (read_issue) begin
      rd_data_q <= store_mem[idx_q[AddrW-1:0]];
    end
  end

  // Binary search bounds and best limit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.search_init) begin
      low_q  <= SumW'(longest_q);
      high_q <= total_q;
      best_q <= '0;
      ok_q   <= 1'b0;
    end else if (cmd_i.mid_calc) begin
      mid_q <= low_q + ((high_q - low_q) >> 1);
    end else if (cmd_i.decide) begin
      if (fits) begin
        best_q <= mid_q;
        ok_q   <= 1'b1;
        high_q <= mid_q - 1'b1;
      end else begin
        low_q <= mid_q + 1'b1;
      end
    end
  end

  // Read sequencing for the greedy scan; one board per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.mid_calc) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      rd_vld_q <= read_issue;
      if (read_issue) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Greedy cut: fail on a board above the limit, else close the group when the next board would exceed it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mid_calc) begin
      gsum_q <= '0;
      gcnt_q <= CntW'(1);
      fail_q <= 1'b0;
    end else if (cmd_i.scan_step && rd_vld_q) begin
      if (len_ext > mid_q) begin
        fail_q <= 1'b1;
      end else if (sum_next <= mid_q) begin
        gsum_q <= sum_next;
      end else begin
        gcnt_q <= gcnt_q + 1'b1;
        gsum_q <= len_ext;
      end
    end
  end

  // Result register; holds until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      min_time_q <= ok_q ? time_sat : '0;
      feasible_q <= ok_q;
      overflow_q <= dropped_q;
    end
  end

  // Status to the controller.
  always_comb begin
    status_o               = '0;
    status_o.painters_zero = (painter_q == '0);
    status_o.low_gt_high   = (low_q > high_q);
    status_o.scan_done     = (idx_q == count_q) && !rd_vld_q;
    status_o.fits          = fits;
    status_o.mid_zero      = (mid_q == '0);
    status_o.out_free      = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign min_time_o  = min_time_q;
  assign feasible_o  = feasible_q;
  assign overflow_o  = overflow_q;

endmodule

>>> src/linear_partition_min_max_sum.sv
// Channel   Direction  Contents                                   Handshake
// board_i   in         board_length, last_board                   valid/ready
// result_o  out        min_time, feasible, overflow               valid/ready
// cfg       in         painter_count (cfg_wdata_i)                cfg_we_i, no wait
//
// Boards are taken one per cycle into the store while no search is running.
// After the last board, the search probes limits between the longest board and the
// total length, at most log2(total - longest + 1) + 1 probes; the single read
// port of the board store scans one board per cycle for each probe. A pending
// result does not block loading of the next set; a search that ends while the
// result still waits holds until it is taken. Reset is asynchronous and leaves
// the block ready for boards.
module linear_partition_min_max_sum #(
  parameter int unsigned MAX_BOARDS  = lpms_pkg::MaxBoardsDefault,
  parameter int unsigned LENGTH_BITS = lpms_pkg::LengthBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpms_pkg::PainterW-1:0] cfg_wdata_i,
  lpms_board_if.sink                    board_i,
  lpms_result_if.source                 result_o
);

  lpms_pkg::cmd_t    cmd;
  lpms_pkg::status_t status;

  // Sequencer for loading, search probes and result hand-off.
  lpms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (board_i.valid),
    .in_last_i  (board_i.last_board),
    .in_ready_o (board_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Board store, search registers and result register.
  lpms_datapath #(
    .MAX_BOARDS  (MAX_BOARDS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .board_length_i (board_i.board_length),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .min_time_o     (result_o.min_time),
    .feasible_o     (result_o.feasible),
    .overflow_o     (result_o.overflow)
  );

endmodule

>>> src/lpms_checker.sv
module lpms_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [lpms_pkg::TimeW-1:0] min_time_i,
  input logic                       feasible_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(min_time_i) && $stable(feasible_i))
    else $error("result request changed while stalled");

  // An infeasible set reports a zero limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !feasible_i |-> min_time_i == '0)
    else $error("infeasible result with nonzero limit");

  // No board is taken in the cycle after the last board of a set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("board request taken during search");

endmodule

bind linear_partition_min_max_sum lpms_checker u_lpms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (board_i.valid),
  .in_ready_i  (board_i.ready),
  .in_last_i   (board_i.last_board),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .min_time_i  (result_o.min_time),
  .feasible_i  (result_o.feasible)
);

>>> tb/linear_partition_min_max_sum_test.sv
module linear_partition_min_max_sum_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BoardCap    = lpms_pkg::MaxBoardsDefault;
  localparam int unsigned LenBits     = lpms_pkg::LengthBitsDefault;
  localparam time         ClkPeriod   = 10ns;
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned HoldCycles  = 2000;
  localparam int unsigned RandomBoards = 210;
  localparam int unsigned PhaseBoards = 36;
  localparam time         WatchdogTime = 20ms;

  typedef struct packed {
    logic [lpms_pkg::TimeW-1:0] min_time;
    logic                       feasible;
    logic                       overflow;
  } partition_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [lpms_pkg::PainterW-1:0] cfg_wdata_i;

  lpms_board_if #(.LENGTH_BITS(LenBits)) board_bus ();
  lpms_result_if                         result_bus ();

  linear_partition_min_max_sum #(
    .MAX_BOARDS (BoardCap),
    .LENGTH_BITS(LenBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .board_i    (board_bus),
    .result_o   (result_bus)
  );

  // Free-running clock.
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mirror of the block's state, updated on every accepted board request and painter write.
  logic [lpms_pkg::PainterW-1:0] painters_now =
    lpms_pkg::PainterW'(lpms_pkg::PainterReset);
  logic [LenBits-1:0]  stored_lengths [BoardCap];
  int unsigned         stored_count = 0;
  longint unsigned     longest_len = 0;
  longint unsigned     total_len = 0;
  bit                  boards_dropped = 1'b0;
  partition_result_t   pending_results [$];

  // Run statistics and error count.
  int unsigned sets_sent = 0;
  int unsigned boards_sent = 0;
  int unsigned results_checked = 0;
  int unsigned dropped_sets = 0;
  int unsigned infeasible_sets = 0;
  int unsigned mismatch_count = 0;

  // Idling controls shared by the test tasks and the result receiver.
  bit board_idling = 1'b0;
  bit result_idling = 1'b0;
  bit hold_request = 1'b0;

  // Greedy left-to-right cut under the given limit.
  function automatic bit greedy_fits(longint unsigned limit);
    longint unsigned run_sum;
    longint unsigned groups;
    run_sum = 0;
    groups  = 1;
    for (int unsigned i = 0; i < stored_count; i++) begin
      if (stored_lengths[i] > limit) return 1'b0;
      if (run_sum + stored_lengths[i] <= limit) begin
        run_sum += stored_lengths[i];
      end else begin
        groups++;
        run_sum = stored_lengths[i];
      end
    end
    return groups <= painters_now;
  endfunction

  // Stores one board and, on the last one, searches for the smallest limit.
  task automatic account_board(input logic [LenBits-1:0] len, input logic last);
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   mid;
    longint unsigned   best;
    bit                found;
    partition_result_t want;
    boards_sent++;
    if (stored_count < BoardCap) begin
      stored_lengths[stored_count] = len;
      stored_count++;
      if (len > longest_len) longest_len = len;
      total_len += len;
    end else begin
      boards_dropped = 1'b1;
    end
    if (last) begin
      best  = 0;
      found = 1'b0;
      if (painters_now != 0) begin
        lo = longest_len;
        hi = total_len;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (greedy_fits(mid)) begin
            best  = mid;
            found = 1'b1;
            if (mid == 0) break;
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
      // The limit saturates at the width of the result field.
      if (!found) want.min_time = '0;
      else if (best > {lpms_pkg::TimeW{1'b1}}) want.min_time = {lpms_pkg::TimeW{1'b1}};
      else want.min_time = lpms_pkg::TimeW'(best);
      want.feasible = found;
      want.overflow = boards_dropped;
      pending_results = {pending_results, want};
      sets_sent++;
      if (boards_dropped) dropped_sets++;
      if (!found) infeasible_sets++;
      stored_count   = 0;
      longest_len    = 0;
      total_len      = 0;
      boards_dropped = 1'b0;
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Result receiver: random stalls, plus one long hold when a test asks for it.
  always begin
    @(negedge clk_i);
    if (hold_request) begin
      result_bus.ready <= 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
      hold_request = 1'b0;
    end else if (result_idling && $urandom_range(0, 3) == 0) begin
      result_bus.ready <= 1'b0;
      repeat (pick_gap()) @(negedge clk_i);
    end
    result_bus.ready <= 1'b1;
  end

  // Each result request is compared with the oldest expectation.
  always @(posedge clk_i) begin
    partition_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("Unexpected result: min_time %0d, feasible %0b, overflow %0b",
               result_bus.min_time, result_bus.feasible, result_bus.overflow);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (result_bus.min_time !== want.min_time) begin
          $error("min_time mismatch: expected %0d, got %0d",
                 want.min_time, result_bus.min_time);
          mismatch_count++;
        end
        if (result_bus.feasible !== want.feasible) begin
          $error("feasible mismatch: expected %0b, got %0b",
                 want.feasible, result_bus.feasible);
          mismatch_count++;
        end
        if (result_bus.overflow !== want.overflow) begin
          $error("overflow mismatch: expected %0b, got %0b",
                 want.overflow, result_bus.overflow);
          mismatch_count++;
        end
      end
    end
  end

  // Offers one board request and waits until the block takes it.
  task automatic send_board(input logic [LenBits-1:0] len, input logic last);
    int unsigned gap;
    gap = (board_idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      board_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    board_bus.valid        <= 1'b1;
    board_bus.board_length <= len;
    board_bus.last_board   <= last;
    do @(posedge clk_i); while (!board_bus.ready);
    account_board(len, last);
  endtask

  // Draws a board length in one of several ranges.
  function automatic logic [LenBits-1:0] pick_length(int unsigned range_sel);
    case (range_sel)
      0: return LenBits'($urandom_range(0, (1 << LenBits) - 1));
      1: return LenBits'($urandom_range(0, 15));
      2: return LenBits'($urandom_range(0, 255));
      default: return ($urandom_range(0, 3) == 0) ? LenBits'($urandom_range(0, 7)) : '0;
    endcase
  endfunction

  // Sends a whole set of random boards with the last flag on the final one.
  task automatic send_random_set(input int unsigned count, input int unsigned range_sel);
    for (int unsigned i = 0; i < count; i++) begin
      send_board(pick_length(range_sel), i == count - 1);
    end
  endtask

  // Drops the board request and waits until every result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    board_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes the painter count while the block is idle.
  task automatic write_painters(input logic [lpms_pkg::PainterW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    painters_now = value;
  endtask

  // The reset value of the painter count gives a single group.
  task automatic test_default_painters();
    send_board(16'd5, 1'b0);
    send_board(16'd3, 1'b0);
    send_board(16'd9, 1'b1);
  endtask

  // Extremes of the fields and the named special cases.
  task automatic test_directed_cases();
    write_painters(16'd2);
    send_board(16'd10, 1'b0);
    send_board(16'd20, 1'b0);
    send_board(16'd30, 1'b0);
    send_board(16'd40, 1'b1);
    send_board(16'hFFFF, 1'b1);
    // All boards zero still give a feasible zero limit.
    send_board(16'd0, 1'b0);
    send_board(16'd0, 1'b0);
    send_board(16'd0, 1'b1);
    // No painters means no partition at all.
    write_painters(16'd0);
    send_board(16'd7, 1'b0);
    send_board(16'hFFFF, 1'b1);
    write_painters(16'hFFFF);
    send_board(16'hFFFF, 1'b0);
    send_board(16'd0, 1'b0);
    send_board(16'd1, 1'b0);
    send_board(16'hFFFF, 1'b1);
    write_painters(16'd3);
    send_board(16'd0, 1'b1);
    // A single painter with a sum wider than one board.
    write_painters(16'd1);
    send_board(16'hFFFF, 1'b0);
    send_board(16'hFFFF, 1'b0);
    send_board(16'hFFFF, 1'b1);
  endtask

  // A store filled exactly, then one overfilled with the last two boards dropped, then a small set.
  task automatic test_store_full();
    write_painters(16'($urandom_range(1, 8)));
    send_random_set(BoardCap, 0);
    send_random_set(BoardCap + 2, 0);
    send_random_set(3, 1);
  endtask

  // The receiver holds off while sets keep coming, so the block backs up.
  task automatic test_backpressure();
    write_painters(16'd2);
    board_idling  = 1'b0;
    result_idling = 1'b0;
    hold_request  = 1'b1;
    for (int unsigned s = 0; s < 5; s++) begin
      send_random_set($urandom_range(3, 6), 0);
    end
  endtask

  // Random sets in phases, each with its own painter count and idling.
  task automatic test_random_sets();
    int unsigned first_board;
    int unsigned phase;
    int unsigned phase_end;
    int unsigned set_size;
    first_board = boards_sent;
    phase = 0;
    while (boards_sent - first_board < RandomBoards) begin
      case (phase % 6)
        0: write_painters(16'd1);
        1: write_painters(16'($urandom_range(2, 4)));
        2: write_painters(16'd0);
        3: write_painters(16'hFFFF);
        4: write_painters(16'($urandom_range(0, 16'hFFFF)));
        default: write_painters(16'($urandom_range(5, 12)));
      endcase
      board_idling  = (phase % 3) != 2;
      result_idling = (phase % 3) != 2;
      phase_end = boards_sent + PhaseBoards;
      while (boards_sent < phase_end) begin
        if ($urandom_range(0, 49) == 0) set_size = $urandom_range(128, BoardCap + 4);
        else set_size = $urandom_range(1, 12);
        send_random_set(set_size, $urandom_range(0, 3));
      end
      phase++;
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    board_bus.valid        = 1'b0;
    board_bus.board_length = '0;
    board_bus.last_board   = 1'b0;
    result_bus.ready       = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_painters();
    test_directed_cases();
    test_store_full();
    test_backpressure();
    test_random_sets();

    // Let the last results arrive and watch for stray ones.
    @(negedge clk_i);
    board_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d results from %0d sets built of %0d boards.",
             results_checked, sets_sent, boards_sent);
    $display("Sets with dropped boards: %0d; sets without a feasible split: %0d.",
             dropped_sets, infeasible_sets);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(WatchdogTime);
    $display("== FAIL ==");
    $finish;
  end

endmodule
